>>> design/streaming_top_n_selector_assert.svh
// assertion macros for the top-n selector top level
// expects a clock named clk and an active-high reset named rst in scope
`ifndef STREAMING_TOP_N_SELECTOR_ASSERT_SVH
`define STREAMING_TOP_N_SELECTOR_ASSERT_SVH

// condition that must hold at every clock edge out of reset
`define TNSEL_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("top-n selector check failed");

// consequence in the same cycle as the trigger
`define TNSEL_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("top-n selector check failed");

// consequence in the cycle after the trigger
`define TNSEL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("top-n selector check failed");

`endif

>>> design/tnsel_pkg.sv
// shared types and constants for the top-n selector
// no dependencies
`timescale 1ns / 1ps

package tnsel_pkg;

  localparam int KEY_W        = 64;
  localparam int ROW_W        = 32;
  localparam int RANK_W       = 4;
  localparam int KEEP_W       = 5;
  localparam int CFG_IDX_W    = 2;
  localparam int DEF_MAX_KEEP = 16;
  localparam int RESULT_CAP   = 16;

  localparam logic [KEEP_W-1:0]    KEEP_RESET     = 5'd16;
  localparam logic [CFG_IDX_W-1:0] REG_SORT_DESC  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_COUNT = 2'd1;

  typedef struct packed {
    logic signed [KEY_W-1:0] row_key;
    logic [ROW_W-1:0]        row_number;
    logic                    end_of_set;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0]  out_row_number;
    logic [RANK_W-1:0] out_rank;
    logic              out_last;
  } out_item_t;

  // contents of one list position
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [ROW_W-1:0]        row;
    logic                    valid;
  } slot_t;

  // controls broadcast along the chain
  typedef struct packed {
    logic insert;
    logic shift_out;
    logic descending;
  } cell_ctl_t;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

endpackage

>>> design/tnsel_cell.sv
// one position of the sorted list: compares the incoming item with its own entry
// depends on tnsel_pkg
`timescale 1ns / 1ps

module tnsel_cell (
  input  logic                clk,
  input  logic                rst,
  input  tnsel_pkg::cell_ctl_t ctl,
  input  logic                enable,
  input  tnsel_pkg::slot_t    new_slot,
  input  tnsel_pkg::slot_t    prev_slot,
  input  logic                prev_take,
  input  tnsel_pkg::slot_t    next_slot,
  output logic                take,
  output tnsel_pkg::slot_t    slot
);

  tnsel_pkg::slot_t slot_next;
  logic             beats;

  // strict win of the new key over the held one
  assign beats = ctl.descending ? (new_slot.key > slot.key) : (new_slot.key < slot.key);
  assign take  = enable & (~slot.valid | beats);

  always_comb begin
    slot_next = slot;
    if (ctl.shift_out) begin
      slot_next = next_slot;
    end else if (ctl.insert && take) begin
      // first winning cell takes the item, the ones behind move down by one
      slot_next = prev_take ? prev_slot : new_slot;
    end
    slot_next.valid = slot_next.valid & enable;
  end

  always_ff @(posedge clk) begin
    slot.key <= slot_next.key;
    slot.row <= slot_next.row;
    if (rst) begin
      slot.valid <= 1'b0;
    end else begin
      slot.valid <= slot_next.valid;
    end
  end

endmodule

>>> design/streaming_top_n_selector.sv
// top level of the streaming top-n selector: control, configuration and the cell chain
// depends on tnsel_pkg, tnsel_cell and streaming_top_n_selector_assert.svh
`timescale 1ns / 1ps
//
// usage
//   input: an item (row_key, row_number, end_of_set) is taken when start is high
//   and busy is low. items without end_of_set never raise busy, so one may be
//   offered every cycle; each is compared against every held entry at once by a
//   row of cells and slotted in ahead of the first entry it strictly beats.
//   output: the item carrying end_of_set is slotted in first, then the held rows
//   come out best first, one per cycle, starting the cycle after that item is
//   taken. result_valid marks each for one cycle; out_rank counts from zero and
//   out_last flags the final row. busy is high while the held rows are emitted
//   (1..effective keep count of them); the emission rate is set by the chain
//   shifting one position per cycle. the receiver cannot stall: every result
//   is taken in the cycle it is shown.
//   configuration: cfg_valid with cfg_index/cfg_data, always ready; index 0 is
//   sort order (1 = largest first), index 1 is keep count (0 acts as 1, values above
//   min(MAX_KEEP, 16) act as it). the user must write only while idle (unchecked);
//   lowering the keep count drops the worst held entries at once.
//   reset: empty list, ascending order, keep count 16, block idle.
//
module streaming_top_n_selector #(
  parameter int MAX_KEEP = tnsel_pkg::DEF_MAX_KEEP
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  tnsel_pkg::in_item_t              item,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tnsel_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tnsel_pkg::KEEP_W-1:0]     cfg_data,
  output logic                             result_valid,
  output tnsel_pkg::out_item_t             result
);

  `include "streaming_top_n_selector_assert.svh"

  // usable chain length, bounded by what one run can emit
  localparam int LIM_CAP = (MAX_KEEP < tnsel_pkg::RESULT_CAP) ? MAX_KEEP
                                                              : tnsel_pkg::RESULT_CAP;

  tnsel_pkg::state_t                  state, state_next;
  logic                               descending;
  logic [tnsel_pkg::KEEP_W-1:0]       keep_count;
  logic [tnsel_pkg::KEEP_W-1:0]       lim;
  logic [tnsel_pkg::RANK_W-1:0]       rank;
  logic                               accept;
  logic                               cfg_write;
  tnsel_pkg::cell_ctl_t               ctl;
  tnsel_pkg::slot_t                   new_slot;
  tnsel_pkg::slot_t                   slots [MAX_KEEP+1];
  logic [MAX_KEEP:0]                  takes;
  logic [MAX_KEEP-1:0]                cell_en;
  logic [MAX_KEEP-1:0]                valid_vec;

  assign accept    = start & ~busy;
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid & cfg_ready;

  // effective keep count: zero acts as one, clipped to the chain
  always_comb begin
    if (keep_count == '0) begin
      lim = tnsel_pkg::KEEP_W'(1);
    end else if (32'(keep_count) > LIM_CAP) begin
      lim = tnsel_pkg::KEEP_W'(LIM_CAP);
    end else begin
      lim = keep_count;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      descending <= 1'b0;
      keep_count <= tnsel_pkg::KEEP_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        tnsel_pkg::REG_SORT_DESC:  descending <= cfg_data[0];
        tnsel_pkg::REG_KEEP_COUNT: keep_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      tnsel_pkg::ST_IDLE: begin
        if (accept && item.end_of_set) begin
          state_next = tnsel_pkg::ST_EMIT;
        end
      end
      tnsel_pkg::ST_EMIT: begin
        // leave once the entry behind the head is empty
        if (!slots[1].valid) begin
          state_next = tnsel_pkg::ST_IDLE;
        end
      end
      default: state_next = tnsel_pkg::ST_IDLE;
    endcase
  end

  // outputs and chain controls
  always_comb begin
    busy                  = 1'b0;
    result_valid          = 1'b0;
    ctl.insert            = 1'b0;
    ctl.shift_out         = 1'b0;
    ctl.descending        = descending;
    result.out_row_number = slots[0].row;
    result.out_rank       = rank;
    result.out_last       = ~slots[1].valid;
    case (state)
      tnsel_pkg::ST_IDLE: begin
        ctl.insert = accept;
      end
      tnsel_pkg::ST_EMIT: begin
        busy          = 1'b1;
        result_valid  = 1'b1;
        ctl.shift_out = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tnsel_pkg::ST_IDLE;
      rank  <= '0;
    end else begin
      state <= state_next;
      if (state == tnsel_pkg::ST_EMIT) begin
        rank <= rank + 1'b1;
      end else begin
        rank <= '0;
      end
    end
  end

  // the chain: cell 0 holds the best entry
  assign new_slot.key   = item.row_key;
  assign new_slot.row   = item.row_number;
  assign new_slot.valid = 1'b1;
  assign takes[0]       = 1'b0;
  assign slots[MAX_KEEP] = '0;

  for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
    tnsel_pkg::slot_t prev;

    if (i == 0) begin : g_head
      assign prev = new_slot;
    end else begin : g_body
      assign prev = slots[i-1];
    end

    assign cell_en[i]   = (32'(lim) > i);
    assign valid_vec[i] = slots[i].valid;

    tnsel_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .enable    (cell_en[i]),
      .new_slot  (new_slot),
      .prev_slot (prev),
      .prev_take (takes[i]),
      .next_slot (slots[i+1]),
      .take      (takes[i+1]),
      .slot      (slots[i])
    );
  end

  // held entries always fill the chain from the head without gaps
  `TNSEL_ASSERT_ALWAYS(a_fill_contiguous, ((valid_vec & (valid_vec + 1'b1)) == '0))
  // never more entries than the effective keep count of the previous cycle
  `TNSEL_ASSERT_ALWAYS(a_fill_within_limit, ($countones(valid_vec) <= 32'($past(lim))))
  // every emitted item comes from a held entry
  `TNSEL_ASSERT_SAME(a_emit_from_held, result_valid, slots[0].valid)
  // a run ending always starts an emission
  `TNSEL_ASSERT_NEXT(a_end_starts_emit, accept && item.end_of_set, busy && result.out_rank == '0)
  // the final item of a run returns the block to idle with an empty list
  `TNSEL_ASSERT_NEXT(a_last_empties, result_valid && result.out_last,
                     !busy && valid_vec == '0)

endmodule
